// ===== hw/rtl/stbs_pkg.sv =====
package stbs_pkg;

  // Field widths fixed by the interface
  localparam int SLOT_W = 10;
  localparam int KEY_W  = 32;
  localparam int CNT_W  = 11;

  // Defaults for the top-level parameters
  localparam int DEPTH_DEF     = 1024;
  localparam int KEY_WIDTH_DEF = 32;

  // Command queue between front and back
  localparam int Q_DEPTH = 4;
  localparam int Q_PW    = $clog2(Q_DEPTH);

  typedef struct packed {
    logic                     action;
    logic [SLOT_W-1:0]        slot;
    logic signed [KEY_W-1:0]  key_value;
  } in_item_t;

  typedef struct packed {
    logic              found;
    logic [SLOT_W-1:0] position;
  } out_item_t;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } op_t;

  typedef struct packed {
    op_t                      op;
    logic [SLOT_W-1:0]        slot;
    logic signed [KEY_W-1:0]  key;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

  typedef struct packed {
    logic searching;
  } back_stat_t;

endpackage

// ===== hw/rtl/stbs_front.sv =====
// Accepts input beats, decodes the action and drops loads outside the table.
module stbs_front #(
  parameter int DEPTH = stbs_pkg::DEPTH_DEF
) (
  input  logic              in_valid,
  output logic              in_ready,
  input  stbs_pkg::in_item_t in_data,
  input  stbs_pkg::q_stat_t q_stat,
  output logic              push,
  output stbs_pkg::cmd_t    push_cmd
);

  stbs_pkg::op_t op;
  logic          drop;

  always_comb begin
    unique case (in_data.action)
      1'b1:    op = stbs_pkg::OP_QUERY;
      default: op = stbs_pkg::OP_LOAD;
    endcase
  end

  assign drop     = (op == stbs_pkg::OP_LOAD) && (32'(in_data.slot) >= 32'(DEPTH));
  assign in_ready = !q_stat.full;
  assign push     = in_valid && in_ready && !drop;

  assign push_cmd.op   = op;
  assign push_cmd.slot = in_data.slot;
  assign push_cmd.key  = in_data.key_value;

endmodule

// ===== hw/rtl/stbs_queue.sv =====
// Small command FIFO between front and back.
module stbs_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  stbs_pkg::cmd_t    push_cmd,
  input  logic              pop,
  output stbs_pkg::cmd_t    head,
  output stbs_pkg::q_stat_t q_stat
);

  stbs_pkg::cmd_t               entry_r [stbs_pkg::Q_DEPTH];
  logic [stbs_pkg::Q_PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [stbs_pkg::Q_PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [stbs_pkg::Q_PW:0]      cnt_r, cnt_nxt;
  logic                         do_push, do_pop;

  assign q_stat.empty = (cnt_r == '0);
  assign q_stat.full  = (cnt_r == (stbs_pkg::Q_PW + 1)'(stbs_pkg::Q_DEPTH));
  assign do_push      = push && !q_stat.full;
  assign do_pop       = pop && !q_stat.empty;
  assign head         = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    case ({do_push, do_pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// ===== hw/rtl/stbs_back.sv =====
// Key table, probe sequencer and result register.
module stbs_back #(
  parameter int DEPTH     = stbs_pkg::DEPTH_DEF,
  parameter int KEY_WIDTH = stbs_pkg::KEY_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [stbs_pkg::CNT_W-1:0] cfg_wdata,
  input  stbs_pkg::q_stat_t          q_stat,
  input  stbs_pkg::cmd_t             head,
  output logic                       pop,
  output logic                       out_valid,
  input  logic                       out_ready,
  output stbs_pkg::out_item_t        out_data,
  output stbs_pkg::back_stat_t       stat
);

  localparam int AW = $clog2(DEPTH);
  localparam int NW = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_PROBE = 2'b10
  } state_t;

  state_t                     state_r, state_nxt;
  logic [stbs_pkg::CNT_W-1:0] entry_count_r;
  logic [NW-1:0]              low_r, low_nxt;
  logic [NW-1:0]              hp_r, hp_nxt;     // exclusive upper bound
  logic [NW-1:0]              mid_r, mid_nxt;
  logic signed [KEY_WIDTH-1:0] qkey_r, qkey_nxt;
  logic signed [KEY_WIDTH-1:0] head_key;
  logic signed [KEY_WIDTH-1:0] rd_data_r;
  logic [KEY_WIDTH-1:0]       key_table [DEPTH];

  logic                       out_valid_r;
  stbs_pkg::out_item_t        out_data_r;

  logic [NW-1:0]              count_c;
  logic [NW-1:0]              low_up;
  logic [NW-1:0]              mid_lt, mid_gt;
  logic                       out_free;
  logic                       we, rd_en;
  logic                       finish, fin_found;

  generate
    if (KEY_WIDTH >= stbs_pkg::KEY_W) begin : g_key_ext
      assign head_key = KEY_WIDTH'(head.key);
    end else begin : g_key_trunc
      assign head_key = $signed(head.key[KEY_WIDTH-1:0]);
    end
  endgenerate

  assign count_c  = (32'(entry_count_r) > 32'(DEPTH)) ? NW'(DEPTH) : NW'(entry_count_r);
  assign out_free = !out_valid_r || out_ready;
  assign low_up   = mid_r + 1'b1;
  assign mid_lt   = NW'(({1'b0, mid_r} + {1'b0, hp_r}) >> 1);
  assign mid_gt   = NW'(({1'b0, low_r} + {1'b0, mid_r} - 1'b1) >> 1);

  always_comb begin
    state_nxt = state_r;
    low_nxt   = low_r;
    hp_nxt    = hp_r;
    mid_nxt   = mid_r;
    qkey_nxt  = qkey_r;
    pop       = 1'b0;
    we        = 1'b0;
    rd_en     = 1'b0;
    finish    = 1'b0;
    fin_found = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (!q_stat.empty) begin
          if (head.op == stbs_pkg::OP_LOAD) begin
            pop = 1'b1;
            we  = 1'b1;
          end else if (out_free) begin
            pop      = 1'b1;
            qkey_nxt = head_key;
            low_nxt  = '0;
            hp_nxt   = count_c;
            if (count_c == '0) begin
              finish = 1'b1;
            end else begin
              mid_nxt   = (count_c - 1'b1) >> 1;
              rd_en     = 1'b1;
              state_nxt = ST_PROBE;
            end
          end
        end
      end
      ST_PROBE: begin
        if (rd_data_r == qkey_r) begin
          finish    = 1'b1;
          fin_found = 1'b1;
          state_nxt = ST_IDLE;
        end else if (rd_data_r < qkey_r) begin
          if (low_up < hp_r) begin
            low_nxt = low_up;
            mid_nxt = mid_lt;
            rd_en   = 1'b1;
          end else begin
            finish    = 1'b1;
            state_nxt = ST_IDLE;
          end
        end else begin
          if (low_r < mid_r) begin
            hp_nxt  = mid_r;
            mid_nxt = mid_gt;
            rd_en   = 1'b1;
          end else begin
            finish    = 1'b1;
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      entry_count_r <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        entry_count_r <= cfg_wdata;
      end
      if (finish) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    low_r  <= low_nxt;
    hp_r   <= hp_nxt;
    mid_r  <= mid_nxt;
    qkey_r <= qkey_nxt;
    if (finish) begin
      out_data_r.found    <= fin_found;
      out_data_r.position <= fin_found ? stbs_pkg::SLOT_W'(mid_r) : '0;
    end
  end

  // Single-port table: loads and probes never share a cycle
  always_ff @(posedge clk) begin
    if (we) begin
      key_table[AW'(head.slot)] <= head_key;
    end
    if (rd_en) begin
      rd_data_r <= key_table[mid_nxt[AW-1:0]];
    end
  end

  assign out_valid      = out_valid_r;
  assign out_data       = out_data_r;
  assign stat.searching = (state_r == ST_PROBE);

endmodule

// ===== hw/rtl/sorted_table_binary_search.sv =====
// Binary search over a table of signed keys held in an on-chip RAM. A beat with
// action 0 writes key_value into the table at slot (slots at or beyond DEPTH are
// dropped); a beat with action 1 searches the first entry_count entries (clamped
// to DEPTH) and returns one beat with found and position (position is 0 when
// absent). Software keeps the table in ascending order; with duplicates the
// first midpoint that hits wins. Input beats pass through a 4-entry command
// queue, so the input side keeps taking beats while the search engine works or
// a result waits on out_ready, until the queue is full. A query makes at most
// floor(log2(count)) + 1 probes; the probe rate is set by the single synchronous
// read port of the key RAM, which serves one midpoint per cycle. An empty table
// is answered without a probe. The user must write entry_count through
// cfg_we/cfg_wdata only while no beat is in flight; the block itself does not
// enforce this. Table contents are undefined until loaded.
module sorted_table_binary_search #(
  parameter int DEPTH     = stbs_pkg::DEPTH_DEF,
  parameter int KEY_WIDTH = stbs_pkg::KEY_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // input beats
  input  logic                       in_valid,
  output logic                       in_ready,
  input  stbs_pkg::in_item_t         in_data,
  // result beats
  output logic                       out_valid,
  input  logic                       out_ready,
  output stbs_pkg::out_item_t        out_data,
  // entry_count register
  input  logic                       cfg_we,
  input  logic [stbs_pkg::CNT_W-1:0] cfg_wdata
);

  logic                 push;
  logic                 pop;
  stbs_pkg::cmd_t       push_cmd;
  stbs_pkg::cmd_t       head;
  stbs_pkg::q_stat_t    q_stat;
  stbs_pkg::back_stat_t back_stat;

  // Front: decode, drop out-of-range loads
  stbs_front #(
    .DEPTH (DEPTH)
  ) u_front (
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_stat   (q_stat),
    .push     (push),
    .push_cmd (push_cmd)
  );

  // Command queue decouples input handshake from the search engine
  stbs_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .q_stat   (q_stat)
  );

  // Back: key RAM, probe loop, result register
  stbs_back #(
    .DEPTH     (DEPTH),
    .KEY_WIDTH (KEY_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_stat    (q_stat),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .stat      (back_stat)
  );

  // A search only starts with the result register free, so it stays empty
  // for the whole probe sequence.
  a_probe_out_empty: assert property (
    @(posedge clk) disable iff (!rst_n)
    back_stat.searching |-> !out_valid
  ) else $error("result pending while probing");

  // Every probe sequence that ends leaves a result beat behind.
  a_search_ends_result: assert property (
    @(posedge clk) disable iff (!rst_n)
    ($fell(back_stat.searching) && $past(rst_n)) |-> out_valid
  ) else $error("search ended without result");

  // Queue occupancy is consistent.
  a_queue_flags: assert property (
    @(posedge clk) disable iff (!rst_n)
    !(q_stat.empty && q_stat.full)
  ) else $error("queue empty and full");

  // Nothing leaves an empty queue.
  a_no_pop_empty: assert property (
    @(posedge clk) disable iff (!rst_n)
    pop |-> !q_stat.empty
  ) else $error("pop from empty queue");

endmodule

// ===== tb/sv/sorted_table_binary_search_test.sv =====
module sorted_table_binary_search_test;
  import stbs_pkg::*;

  typedef logic signed [KEY_W-1:0] key_t;

  localparam int TABLE_DEPTH  = DEPTH_DEF;
  // drain margin after the last result; queued loads retire one per cycle once the engine is idle
  localparam int DRAIN_CYCLES = 20;
  // long receiver hold-off, well past what the 4-deep command queue absorbs
  localparam int HOLD_CYCLES  = 300;
  localparam int RANDOM_ITEMS = 300;
  localparam int MAX_REPORTS  = 10;
  localparam int IDLE_PCT     = 32;
  localparam longint RUN_LIMIT = 4_000_000;
  localparam key_t KEY_MIN = {1'b1, {(KEY_W-1){1'b0}}};
  localparam key_t KEY_MAX = ~KEY_MIN;
  localparam key_t KEY_NEG_ONE = -1;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  in_item_t           in_data = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  out_item_t          out_data;
  logic               cfg_we = 1'b0;
  logic [CNT_W-1:0]   cfg_wdata = '0;

  sorted_table_binary_search dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Hard stop in case a handshake never completes.
  initial begin
    #(RUN_LIMIT);
    $display("[FAIL] regression broken");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Search predictor: own copy of the key table and of entry_count, updated
  // from the beats and register writes actually seen at the clock edge.
  // ---------------------------------------------------------------------------
  key_t              model_keys [TABLE_DEPTH];
  logic [CNT_W-1:0]  model_count = '0;
  out_item_t         expected_results [$];
  out_item_t         want;

  int failures     = 0;
  int loads_seen   = 0;
  int queries_seen = 0;
  int hits_seen    = 0;
  int results_seen = 0;

  function automatic out_item_t search_table(key_t key);
    int lo, hi, mid, n;
    out_item_t r;
    // counts above the table size search the whole table
    n  = (model_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(model_count);
    r  = '0;
    lo = 0;
    hi = n - 1;
    while (lo <= hi && !r.found) begin
      mid = (lo + hi) / 2;
      if (model_keys[mid] == key) begin
        // with duplicate keys the first probe that hits wins
        r.found    = 1'b1;
        r.position = SLOT_W'(mid);
      end else if (model_keys[mid] < key) begin
        lo = mid + 1;
      end else begin
        hi = mid - 1;
      end
    end
    return r;
  endfunction

  function void note_failure(string msg);
    failures++;
    if (failures <= MAX_REPORTS) $display("ERROR: %s", msg);
  endfunction

  // Result check first, then the input beat of the same edge. A query's
  // result can never come at the edge it was accepted, so order is safe.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          note_failure($sformatf("result beat found=%0b position=%0d with none pending",
                                 out_data.found, out_data.position));
        end else begin
          want = expected_results.pop_front();
          if (out_data.found !== want.found || out_data.position !== want.position)
            note_failure($sformatf("result %0d: expected found=%0b position=%0d, got found=%0b position=%0d",
                                   results_seen, want.found, want.position,
                                   out_data.found, out_data.position));
        end
      end
      if (cfg_we) model_count = cfg_wdata;
      if (in_valid && in_ready) begin
        if (in_data.action == OP_QUERY) begin
          want = search_table(in_data.key_value);
          expected_results.push_back(want);
          queries_seen++;
          if (want.found) hits_seen++;
        end else begin
          model_keys[in_data.slot] = in_data.key_value;
          loads_seen++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stalls, plus a long hold-off on request. The request is
  // a counter bumped by the test; the hold length is counted here.
  // ---------------------------------------------------------------------------
  int tx_idle_pct = IDLE_PCT;
  int rx_idle_pct = IDLE_PCT;
  int hold_req    = 0;
  int hold_seen   = 0;
  int hold_left   = 0;

  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------
  key_t issued_keys [TABLE_DEPTH];   // what the test has loaded, for key picks
  bit   path_marks  [TABLE_DEPTH];   // slots on chosen probe paths
  int   active_count = 0;            // entry_count clamped to the table size
  int   items_sent   = 0;

  // Called at a clock edge. valid is only dropped when a gap is taken, so it
  // is never lowered and raised in the same step.
  task automatic send_beat(input in_item_t item);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  task automatic send_load(input int slot, input key_t key);
    in_item_t item;
    item.action    = OP_LOAD;
    item.slot      = SLOT_W'(slot);
    item.key_value = key;
    issued_keys[slot] = key;
    send_beat(item);
  endtask

  task automatic send_query(input key_t key);
    in_item_t item;
    item.action    = OP_QUERY;
    // slot is unused by a query; random bits so it is not assumed zero
    item.slot      = SLOT_W'($urandom);
    item.key_value = key;
    send_beat(item);
  endtask

  // Stop offering beats until every result is back, then let queued loads
  // retire. The first edge lets the checker record a beat taken this step.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Only call while drained.
  task automatic write_count(input int value);
    cfg_we    <= 1'b1;
    cfg_wdata <= CNT_W'(value);
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
    active_count = (value > TABLE_DEPTH) ? TABLE_DEPTH : value;
  endtask

  // Marks every slot probed by a full-table search that ends at target.
  function automatic void mark_path(input int target);
    int lo, hi, mid;
    lo = 0;
    hi = TABLE_DEPTH - 1;
    while (lo <= hi) begin
      mid = (lo + hi) / 2;
      path_marks[mid] = 1'b1;
      if (mid == target) break;
      if (mid < target) lo = mid + 1;
      else hi = mid - 1;
    end
  endfunction

  // Keys from the table half the time, else neighbors, noise or key extremes.
  function automatic key_t pick_query_key();
    int r;
    key_t k;
    r = $urandom_range(99);
    if (active_count > 0 && r < 50) begin
      k = issued_keys[$urandom_range(active_count - 1)];
    end else if (active_count > 0 && r < 70) begin
      k = issued_keys[$urandom_range(active_count - 1)];
      k = $urandom_range(1) ? k + 1 : k - 1;
    end else if (r < 85) begin
      k = key_t'($urandom);
    end else begin
      case ($urandom_range(3))
        0: k = KEY_MIN;
        1: k = KEY_MAX;
        2: k = '0;
        default: k = KEY_NEG_ONE;
      endcase
    end
    return k;
  endfunction

  // Ascending keys in slots 0..n-1, with duplicates and saturation at the top.
  task automatic load_ascending(input int n, inout int sent);
    longint v;
    v = longint'($signed($urandom));
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(3))
        0: v = v;                                     // duplicate
        1: v = v + $urandom_range(1, 8);
        default: v = v + $urandom_range(1, 1 << 24);
      endcase
      if (v > longint'(KEY_MAX)) v = longint'(KEY_MAX);
      send_load(i, key_t'(v[KEY_W-1:0]));
      sent++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // entry_count is 0 out of reset: nothing is read, nothing is found.
  task automatic test_empty_table();
    send_query(KEY_MIN);
    send_query(KEY_MAX);
    send_query('0);
    wait_drained();
    write_count(0);
    send_query(KEY_NEG_ONE);
    wait_drained();
  endtask

  task automatic test_single_entry();
    write_count(1);
    send_load(0, KEY_NEG_ONE);
    send_query(KEY_NEG_ONE);
    send_query('0);
    send_query(KEY_MIN);
    wait_drained();
  endtask

  // Both key extremes in the table, duplicate runs, absent keys in between.
  task automatic test_small_sorted();
    key_t keys [7];
    keys = '{KEY_MIN, -5, -5, 0, 7, 7, KEY_MAX};
    write_count(7);
    foreach (keys[i]) send_load(i, keys[i]);
    send_query(KEY_MIN);
    send_query(KEY_MAX);
    send_query(-5);
    send_query(7);
    send_query('0);
    send_query(3);
    send_query(-6);
    wait_drained();
  endtask

  // Largest and clamped counts. Only the probe paths ending at a few slots
  // (both ends among them) are loaded, keys rising with the slot over the
  // whole key range; queries ask for loaded keys only, so every probe reads
  // a loaded slot. No idling here.
  task automatic test_large_table();
    longint v;
    int     marked [$];
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    mark_path(0);
    mark_path(TABLE_DEPTH - 1);
    repeat (6) mark_path($urandom_range(TABLE_DEPTH - 1));
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (path_marks[i]) begin
        v = longint'(KEY_MIN) + longint'(i) * (longint'(1) << 22)
            + longint'($urandom_range(0, (1 << 22) - 1));
        if (i == 0) v = longint'(KEY_MIN);
        if (i == TABLE_DEPTH - 1) v = longint'(KEY_MAX);
        send_load(i, key_t'(v[KEY_W-1:0]));
        marked.push_back(i);
      end
    end
    wait_drained();
    write_count(TABLE_DEPTH);
    repeat (16) send_query(issued_keys[marked[$urandom_range(marked.size() - 1)]]);
    send_query(KEY_MIN);
    send_query(KEY_MAX);
    wait_drained();
    write_count((1 << CNT_W) - 1);
    repeat (6) send_query(issued_keys[marked[$urandom_range(marked.size() - 1)]]);
    wait_drained();
    write_count(TABLE_DEPTH + 1);
    repeat (4) send_query(issued_keys[marked[$urandom_range(marked.size() - 1)]]);
    wait_drained();
    tx_idle_pct = IDLE_PCT;
    rx_idle_pct = IDLE_PCT;
  endtask

  // Receiver holds off while queries keep coming: the queue fills and the
  // input side has to stall. Then the sender waits for everything to return.
  task automatic test_backpressure();
    int loaded;
    loaded = 0;
    write_count(16);
    load_ascending(16, loaded);
    tx_idle_pct = 0;
    hold_req++;
    repeat (16) send_query(pick_query_key());
    wait_drained();
    tx_idle_pct = IDLE_PCT;
  endtask

  // Sequences: set a count, load a sorted prefix, query it. A few sequences
  // add a stray load that breaks the order, or use an empty count.
  task automatic test_random_sequences();
    int sent, r, n;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      wait_drained();
      r = $urandom_range(99);
      if (r < 70)      n = $urandom_range(1, 16);
      else if (r < 94) n = $urandom_range(17, 96);
      else             n = 0;
      write_count(n);
      if (active_count > 0 && active_count <= 96) load_ascending(active_count, sent);
      if ($urandom_range(9) == 0) begin
        send_load($urandom_range(TABLE_DEPTH - 1), key_t'($urandom));
        sent++;
      end
      repeat ($urandom_range(3, 12)) begin
        send_query(pick_query_key());
        sent++;
      end
    end
    wait_drained();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_table();
    test_single_entry();
    test_small_sorted();
    test_large_table();
    test_backpressure();
    test_random_sequences();

    wait_drained();
    if (expected_results.size() != 0)
      note_failure($sformatf("%0d results never arrived", expected_results.size()));

    $display("Covered %0d beats: %0d table loads, %0d searches (%0d hits), %0d results checked.",
             items_sent, loads_seen, queries_seen, hits_seen, results_seen);
    $display("Counts 0 to 2047 with clamping, sparse large and empty tables, duplicates, long stall; %0d failures.",
             failures);
    if (failures == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
